### sv/texc_pkg.sv
`timescale 1ns / 1ps

package texc_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int KEY_BITS_DEF = 32;

   localparam int TOTAL_W = 36;
   localparam int BYTES_W = 31;

   localparam logic [TOTAL_W-1:0] MAX_BYTES_RST = 36'd67108864;
   localparam logic [BYTES_W-1:0] BYTES_MAX     = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      ACT_PUT    = 2'd0,
      ACT_GET    = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NOT_FOUND  = 2'd1,
      ST_BAD_FORMAT = 2'd2
   } status_type;

   localparam logic KIND_FINAL  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [2:0] PK_LUM8      = 3'd0;
   localparam logic [2:0] PK_LUMALPHA8 = 3'd1;
   localparam logic [2:0] PK_RGB8      = 3'd2;
   localparam logic [2:0] PK_RGBA8     = 3'd3;
   localparam logic [2:0] PK_RGBA5551  = 3'd4;
   localparam logic [2:0] PK_RGB565    = 3'd5;

   // bytes per pixel; zero marks an unsupported format
   function automatic logic [2:0] bytes_per_pixel(input logic [2:0] kind);
      logic [2:0] bpp;
      case (kind)
         PK_LUM8:      bpp = 3'd1;
         PK_LUMALPHA8: bpp = 3'd2;
         PK_RGB8:      bpp = 3'd3;
         PK_RGBA8:     bpp = 3'd4;
         PK_RGBA5551:  bpp = 3'd2;
         PK_RGB565:    bpp = 3'd2;
         default:      bpp = 3'd0;
      endcase
      return bpp;
   endfunction

   // queue handshake between front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### sv/texc_fifo.sv
`timescale 1ns / 1ps

module texc_fifo #(
   parameter int WIDTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output texc_pkg::q_status_type  status
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == 2'd2);
   assign status.empty = (fill_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### sv/texc_front.sv
`timescale 1ns / 1ps

module texc_front #(
   parameter int KEY_BITS = texc_pkg::KEY_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_action,
   input  logic [31:0]            req_key,
   input  logic [31:0]            req_entry_handle,
   input  logic [15:0]            req_entry_hints,
   input  logic [2:0]             req_pixel_kind,
   input  logic [14:0]            req_tex_width,
   input  logic [14:0]            req_tex_height,
   output logic                   q_push,
   output logic [KEY_BITS+81:0]   q_item,
   input  texc_pkg::q_status_type q_status
);

   typedef struct packed {
      logic [1:0]                     action;
      logic                           bad_fmt;
      logic [KEY_BITS-1:0]            key;
      logic [31:0]                    handle;
      logic [15:0]                    hints;
      logic [texc_pkg::BYTES_W-1:0]   bytes;
   } item_type;

   logic                s1_valid_ff, s1_valid_in;
   item_type            s1_item_ff, s1_item_in;
   logic [29:0]         s1_wh_ff, s1_wh_in;
   logic [2:0]          s1_bpp_ff, s1_bpp_in;
   logic [KEY_BITS-1:0] key_int;
   logic                load;
   logic [32:0]         prod;
   item_type            out_item;

   generate
      if (KEY_BITS >= 32) begin : g_key_wide
         assign key_int = KEY_BITS'(req_key);
      end else begin : g_key_narrow
         assign key_int = req_key[KEY_BITS-1:0];
      end
   endgenerate

   assign req_stall = s1_valid_ff && q_status.full;
   assign q_push    = s1_valid_ff && !q_status.full;
   assign load      = req_valid && !req_stall;

   always_comb begin
      s1_bpp_in          = texc_pkg::bytes_per_pixel(req_pixel_kind);
      s1_wh_in           = 30'(req_tex_width) * 30'(req_tex_height);
      s1_item_in.action  = req_action;
      s1_item_in.bad_fmt = (s1_bpp_in == 3'd0);
      s1_item_in.key     = key_int;
      s1_item_in.handle  = req_entry_handle;
      s1_item_in.hints   = req_entry_hints;
      s1_item_in.bytes   = '0;
      s1_valid_in        = load ? 1'b1 : (q_push ? 1'b0 : s1_valid_ff);
   end

   // second multiply, saturated to the 31-bit entry size
   always_comb begin
      prod           = 33'(s1_bpp_ff) * 33'(s1_wh_ff);
      out_item       = s1_item_ff;
      out_item.bytes = (prod > 33'(texc_pkg::BYTES_MAX)) ? texc_pkg::BYTES_MAX
                                                          : prod[30:0];
   end

   assign q_item = out_item;

   always_ff @(posedge clock) begin
      if (load) begin
         s1_item_ff <= s1_item_in;
         s1_wh_ff   <= s1_wh_in;
         s1_bpp_ff  <= s1_bpp_in;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

endmodule

### sv/texc_back.sv
`timescale 1ns / 1ps

module texc_back #(
   parameter int CAPACITY = texc_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = texc_pkg::KEY_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [KEY_BITS+81:0]          q_item,
   input  texc_pkg::q_status_type        q_status,
   output logic                          q_pop,
   input  logic [texc_pkg::TOTAL_W-1:0]  max_bytes,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [1:0]                    rsp_status,
   output logic [31:0]                   rsp_key_out,
   output logic [31:0]                   rsp_handle_out,
   output logic [15:0]                   rsp_hints_out,
   output logic [35:0]                   rsp_total_bytes,
   output logic [5:0]                    rsp_entry_count,
   output logic                          rsp_last
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int TW     = texc_pkg::TOTAL_W;

   typedef struct packed {
      logic [1:0]                     action;
      logic                           bad_fmt;
      logic [KEY_BITS-1:0]            key;
      logic [31:0]                    handle;
      logic [15:0]                    hints;
      logic [texc_pkg::BYTES_W-1:0]   bytes;
   } item_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]            key;
      logic [31:0]                    handle;
      logic [15:0]                    hints;
      logic [texc_pkg::BYTES_W-1:0]   bytes;
   } ent_type;

   typedef enum logic [3:0] {
      S_IDLE, S_LOOK, S_FULLCHK, S_INSERT, S_BUDGET, S_CLEAR,
      S_REL_RD, S_REL_EMIT, S_FIN_RD, S_FIN_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_SAME, PH_FULL, PH_BUDGET, PH_REMOVE, PH_CLEAR
   } phase_type;

   typedef enum logic [1:0] {FIN_ZERO, FIN_CUR, FIN_MEM} fin_type;

   // entry payload store
   ent_type             mem [CAPACITY];
   ent_type             rd_ff;
   logic                mem_we;
   logic [SLOT_W-1:0]   mem_wa;
   ent_type             mem_wd;

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   fin_type             fin_ff, fin_in;
   texc_pkg::status_type fin_status_ff, fin_status_in;
   item_type            cur_ff, cur_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [KEY_BITS-1:0] key_ff [CAPACITY];
   logic [KEY_BITS-1:0] key_in [CAPACITY];
   logic [SLOT_W-1:0]   order_ff [CAPACITY];
   logic [SLOT_W-1:0]   order_in [CAPACITY];
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TW-1:0]       total_ff, total_in;
   logic [SLOT_W-1:0]   rel_slot_ff, rel_slot_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0] rsp_key_ff, rsp_key_in;
   logic [31:0]         rsp_handle_ff, rsp_handle_in;
   logic [15:0]         rsp_hints_ff, rsp_hints_in;
   logic [TW-1:0]       rsp_total_ff, rsp_total_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [CAPACITY-1:0] match;
   logic                found;
   logic [SLOT_W-1:0]   fslot;
   logic [SLOT_W-1:0]   free_slot;
   logic [CAPACITY-1:0] shift_sel;
   logic                above;
   logic [TW-1:0]       total_rel;
   logic                out_free;
   logic                emit;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cur_in   = q_item;

   // key search, free-slot pick and age-queue removal mask
   always_comb begin
      found     = 1'b0;
      fslot     = '0;
      free_slot = '0;
      above     = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == cur_ff.key);
         if (match[i]) begin
            fslot = fslot | SLOT_W'(i);
         end
         above = above || ((order_ff[i] == rel_slot_ff) && (CNT_W'(i) < count_ff));
         shift_sel[i] = above;
      end
      found = |match;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
      total_rel = (total_ff >= TW'(rd_ff.bytes)) ? total_ff - TW'(rd_ff.bytes) : '0;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      fin_in        = fin_ff;
      fin_status_in = fin_status_ff;
      valid_in      = valid_ff;
      key_in        = key_ff;
      order_in      = order_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      rel_slot_in   = rel_slot_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = free_slot;
      mem_wd.key    = cur_ff.key;
      mem_wd.handle = cur_ff.handle;
      mem_wd.hints  = cur_ff.hints;
      mem_wd.bytes  = cur_ff.bytes;
      emit          = 1'b0;
      rsp_kind_in   = texc_pkg::KIND_FINAL;
      rsp_status_in = fin_status_ff;
      rsp_key_in    = '0;
      rsp_handle_in = '0;
      rsp_hints_in  = '0;
      rsp_total_in  = total_ff;
      rsp_count_in  = count_ff;
      rsp_last_in   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            fin_in        = FIN_ZERO;
            fin_status_in = texc_pkg::ST_OK;
            rel_slot_in   = fslot;
            case (texc_pkg::action_type'(cur_ff.action))
               texc_pkg::ACT_PUT: begin
                  if (cur_ff.bad_fmt) begin
                     fin_status_in = texc_pkg::ST_BAD_FORMAT;
                     state_in      = S_FIN_EMIT;
                  end else if (found) begin
                     phase_in = PH_SAME;
                     state_in = S_REL_RD;
                  end else begin
                     state_in = S_FULLCHK;
                  end
               end
               texc_pkg::ACT_GET: begin
                  if (found) begin
                     fin_in   = FIN_MEM;
                     state_in = S_FIN_RD;
                  end else begin
                     fin_status_in = texc_pkg::ST_NOT_FOUND;
                     state_in      = S_FIN_EMIT;
                  end
               end
               texc_pkg::ACT_REMOVE: begin
                  if (found) begin
                     phase_in = PH_REMOVE;
                     state_in = S_REL_RD;
                  end else begin
                     fin_status_in = texc_pkg::ST_NOT_FOUND;
                     state_in      = S_FIN_EMIT;
                  end
               end
               default: begin
                  state_in = S_CLEAR;
               end
            endcase
         end
         S_FULLCHK: begin
            if (count_ff >= CNT_W'(CAPACITY)) begin
               rel_slot_in = order_ff[0];
               phase_in    = PH_FULL;
               state_in    = S_REL_RD;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            mem_we                          = 1'b1;
            valid_in[free_slot]             = 1'b1;
            key_in[free_slot]               = cur_ff.key;
            order_in[count_ff[SLOT_W-1:0]]  = free_slot;
            count_in                        = count_ff + 1'b1;
            total_in                        = total_ff + TW'(cur_ff.bytes);
            state_in                        = S_BUDGET;
         end
         S_BUDGET: begin
            if ((total_ff > max_bytes) && (count_ff > CNT_W'(1))) begin
               rel_slot_in = order_ff[0];
               phase_in    = PH_BUDGET;
               state_in    = S_REL_RD;
            end else begin
               fin_in   = FIN_CUR;
               state_in = S_FIN_EMIT;
            end
         end
         S_CLEAR: begin
            if (count_ff != '0) begin
               rel_slot_in = order_ff[0];
               phase_in    = PH_CLEAR;
               state_in    = S_REL_RD;
            end else begin
               fin_in   = FIN_ZERO;
               state_in = S_FIN_EMIT;
            end
         end
         S_REL_RD: begin
            state_in = S_REL_EMIT;
         end
         S_REL_EMIT: begin
            rsp_kind_in   = texc_pkg::KIND_REPORT;
            rsp_status_in = texc_pkg::ST_OK;
            rsp_key_in    = rd_ff.key;
            rsp_handle_in = rd_ff.handle;
            rsp_hints_in  = rd_ff.hints;
            rsp_total_in  = total_rel;
            rsp_count_in  = count_ff - 1'b1;
            rsp_last_in   = 1'b0;
            if (out_free) begin
               emit                  = 1'b1;
               valid_in[rel_slot_ff] = 1'b0;
               count_in              = count_ff - 1'b1;
               total_in              = total_rel;
               for (int i = 0; i < CAPACITY; i++) begin
                  if (shift_sel[i]) begin
                     order_in[i] = order_ff[(i + 1) % CAPACITY];
                  end
               end
               case (phase_ff)
                  PH_SAME:   state_in = S_FULLCHK;
                  PH_FULL:   state_in = S_INSERT;
                  PH_BUDGET: state_in = S_BUDGET;
                  PH_REMOVE: begin
                     fin_in   = FIN_MEM;
                     state_in = S_FIN_EMIT;
                  end
                  default:   state_in = S_CLEAR;
               endcase
            end
         end
         S_FIN_RD: begin
            state_in = S_FIN_EMIT;
         end
         S_FIN_EMIT: begin
            case (fin_ff)
               FIN_CUR: begin
                  rsp_key_in    = cur_ff.key;
                  rsp_handle_in = cur_ff.handle;
                  rsp_hints_in  = cur_ff.hints;
               end
               FIN_MEM: begin
                  rsp_key_in    = rd_ff.key;
                  rsp_handle_in = rd_ff.handle;
                  rsp_hints_in  = rd_ff.hints;
               end
               default: begin
                  rsp_key_in = '0;
               end
            endcase
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[rel_slot_ff];
   end

   always_ff @(posedge clock) begin
      cur_ff <= (q_pop) ? cur_in : cur_ff;
      key_ff        <= key_in;
      order_ff      <= order_in;
      rel_slot_ff   <= rel_slot_in;
      phase_ff      <= phase_in;
      fin_ff        <= fin_in;
      fin_status_ff <= fin_status_in;
      if (emit) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_hints_ff  <= rsp_hints_in;
         rsp_total_ff  <= rsp_total_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   generate
      if (KEY_BITS >= 32) begin : g_kout_wide
         assign rsp_key_out = rsp_key_ff[31:0];
      end else begin : g_kout_narrow
         assign rsp_key_out = 32'(rsp_key_ff);
      end
   endgenerate

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_handle_out  = rsp_handle_ff;
   assign rsp_hints_out   = rsp_hints_ff;
   assign rsp_total_bytes = rsp_total_ff;
   assign rsp_entry_count = 6'(rsp_count_ff);
   assign rsp_last        = rsp_last_ff;

endmodule

### sv/size_bounded_fifo_texture_cache_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Carries
// req_*     in         req_valid/req_stall  one cache request transaction
// rsp_*     out        rsp_valid/rsp_stall  release reports, then one final status
// csr_*     in         csr_wr_en            byte budget (max_bytes), no read-back
//
// Sequence: a transaction is registered in the front stage (size multiply), then
// queued and popped once the back is idle. A miss or bad format goes to the final
// status; a get reads the entry, a remove reports and releases it; a put releases
// a same-key entry, releases the oldest if full, inserts, then evicts while over
// budget with more than one entry held; a clear evicts until empty. Then the back
// idles before the next pop. Reset is synchronous and clears the table at once
// (valid bits in flops); budget returns to 64 MiB. A stalled result holds the
// sequencer while the front and queue keep taking up to three more transactions.

module size_bounded_fifo_texture_cache_unit #(
   parameter int CAPACITY = texc_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = texc_pkg::KEY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_key,
   input  logic [31:0] req_entry_handle,
   input  logic [15:0] req_entry_hints,
   input  logic [2:0]  req_pixel_kind,
   input  logic [14:0] req_tex_width,
   input  logic [14:0] req_tex_height,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_key_out,
   output logic [31:0] rsp_handle_out,
   output logic [15:0] rsp_hints_out,
   output logic [35:0] rsp_total_bytes,
   output logic [5:0]  rsp_entry_count,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [35:0] csr_wr_data
);

   localparam int ITEM_W = KEY_BITS + 82;

   // byte budget register
   logic [texc_pkg::TOTAL_W-1:0] max_bytes_ff, max_bytes_in;

   // front to back queue
   logic                   q_push;
   logic                   q_pop;
   logic [ITEM_W-1:0]      q_wr_item;
   logic [ITEM_W-1:0]      q_rd_item;
   texc_pkg::q_status_type q_status;

   assign max_bytes_in = csr_wr_en ? csr_wr_data : max_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= texc_pkg::MAX_BYTES_RST;
      end else begin
         max_bytes_ff <= max_bytes_in;
      end
   end

   // front: takes the transaction, sizes the texture, flags bad formats
   texc_front #(
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_key          (req_key),
      .req_entry_handle (req_entry_handle),
      .req_entry_hints  (req_entry_hints),
      .req_pixel_kind   (req_pixel_kind),
      .req_tex_width    (req_tex_width),
      .req_tex_height   (req_tex_height),
      .q_push           (q_push),
      .q_item           (q_wr_item),
      .q_status         (q_status)
   );

   // two-deep queue lets front and back stall independently
   texc_fifo #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_item),
      .pop       (q_pop),
      .pop_data  (q_rd_item),
      .status    (q_status)
   );

   // back: key search, insertion-order list, evictions and reporting
   texc_back #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_item          (q_rd_item),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .max_bytes       (max_bytes_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_status      (rsp_status),
      .rsp_key_out     (rsp_key_out),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_hints_out   (rsp_hints_out),
      .rsp_total_bytes (rsp_total_bytes),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

endmodule

### sv/texc_checker.sv
`timescale 1ns / 1ps

module texc_props #(
   parameter int CAPACITY = texc_pkg::CAPACITY_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_key_out,
   input logic [5:0]  rsp_entry_count,
   input logic        rsp_last
);

   // a stalled result stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // reports never close a transaction, finals always do
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind == texc_pkg::KIND_FINAL)))
      else $error("last flag does not match result kind");

   // failed requests carry no entry
   a_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != texc_pkg::ST_OK) |->
         (rsp_kind == texc_pkg::KIND_FINAL) && (rsp_key_out == '0))
      else $error("failed request carries entry data");

   // occupancy never exceeds the table
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= 6'(CAPACITY)))
      else $error("entry count beyond capacity");

endmodule

bind size_bounded_fifo_texture_cache_unit texc_props #(
   .CAPACITY (CAPACITY)
) u_texc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_status      (rsp_status),
   .rsp_key_out     (rsp_key_out),
   .rsp_entry_count (rsp_entry_count),
   .rsp_last        (rsp_last)
);

### bench/texc_checker.sv
`timescale 1ns / 1ps

module texc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_key,
   input  logic [31:0] req_entry_handle,
   input  logic [15:0] req_entry_hints,
   input  logic [2:0]  req_pixel_kind,
   input  logic [14:0] req_tex_width,
   input  logic [14:0] req_tex_height,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_kind,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_key_out,
   input  logic [31:0] rsp_handle_out,
   input  logic [15:0] rsp_hints_out,
   input  logic [35:0] rsp_total_bytes,
   input  logic [5:0]  rsp_entry_count,
   input  logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [35:0] csr_wr_data,
   output int          fail_count,
   output int          pending_count
);

   localparam int SLOTS = 32;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [31:0] key;
      logic [31:0] handle;
      logic [15:0] hints;
      logic [35:0] total;
      logic [5:0]  count;
      logic        last;
   } cache_rsp_type;

   cache_rsp_type expected_rsps[$];

   logic [35:0] budget;
   logic        e_valid  [SLOTS];
   logic [31:0] e_key    [SLOTS];
   logic [31:0] e_handle [SLOTS];
   logic [15:0] e_hints  [SLOTS];
   logic [30:0] e_bytes  [SLOTS];
   int          e_next   [SLOTS];
   int          e_prev   [SLOTS];
   int          oldest, newest, held;
   logic [35:0] held_bytes;

   function automatic void push_rsp(logic kind, logic [1:0] st, logic [31:0] k,
                                    logic [31:0] hd, logic [15:0] hn, logic last);
      cache_rsp_type r;
      r = '{kind, st, k, hd, hn, held_bytes, held[5:0], last};
      expected_rsps.push_back(r);
   endfunction

   function automatic void drop_entry(int s);
      int p, q;
      p = e_prev[s];
      q = e_next[s];
      if (held <= 1) begin
         oldest = 0;
         newest = 0;
      end else begin
         if (s == oldest) oldest = q;
         else e_next[p] = q;
         if (s == newest) newest = p;
         else e_prev[q] = p;
      end
      e_valid[s] = 1'b0;
      if (held > 0) held--;
      held_bytes = (held_bytes >= e_bytes[s]) ? held_bytes - e_bytes[s] : '0;
      push_rsp(texc_pkg::KIND_REPORT, texc_pkg::ST_OK, e_key[s], e_handle[s],
               e_hints[s], 1'b0);
   endfunction

   function automatic int lookup(logic [31:0] k);
      for (int i = 0; i < SLOTS; i++)
         if (e_valid[i] && e_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void predict_request(logic [1:0] act, logic [31:0] k,
                                           logic [31:0] hd, logic [15:0] hn,
                                           logic [2:0] pk, logic [14:0] w,
                                           logic [14:0] h);
      int          f, s;
      logic [3:0]  bpp;
      logic [63:0] sz;
      case (act)
         texc_pkg::ACT_PUT: begin
            case (pk)
               texc_pkg::PK_LUM8:      bpp = 4'd1;
               texc_pkg::PK_LUMALPHA8: bpp = 4'd2;
               texc_pkg::PK_RGBA5551:  bpp = 4'd2;
               texc_pkg::PK_RGB565:    bpp = 4'd2;
               texc_pkg::PK_RGB8:      bpp = 4'd3;
               texc_pkg::PK_RGBA8:     bpp = 4'd4;
               default:                bpp = 4'd0;
            endcase
            if (bpp == 4'd0) begin
               push_rsp(texc_pkg::KIND_FINAL, texc_pkg::ST_BAD_FORMAT, '0, '0, '0, 1'b1);
               return;
            end
            sz = 64'(bpp) * 64'(w) * 64'(h);
            if (sz > 64'(texc_pkg::BYTES_MAX)) sz = 64'(texc_pkg::BYTES_MAX);
            f = lookup(k);
            if (f >= 0) drop_entry(f);
            if (held >= SLOTS) drop_entry(oldest);
            for (s = 0; s < SLOTS && e_valid[s]; s++) ;
            if (s >= SLOTS) s = 0;
            e_valid[s] = 1'b1;
            e_key[s] = k;
            e_handle[s] = hd;
            e_hints[s] = hn;
            e_bytes[s] = sz[30:0];
            e_next[s] = 0;
            if (held == 0) begin
               e_prev[s] = 0;
               oldest = s;
            end else begin
               e_prev[s] = newest;
               e_next[newest] = s;
            end
            newest = s;
            held++;
            held_bytes = held_bytes + sz[35:0];
            while (held_bytes > budget && held > 1) drop_entry(oldest);
            push_rsp(texc_pkg::KIND_FINAL, texc_pkg::ST_OK, k, hd, hn, 1'b1);
         end
         texc_pkg::ACT_GET, texc_pkg::ACT_REMOVE: begin
            f = lookup(k);
            if (f < 0) begin
               push_rsp(texc_pkg::KIND_FINAL, texc_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
            end else begin
               if (act == texc_pkg::ACT_REMOVE) drop_entry(f);
               push_rsp(texc_pkg::KIND_FINAL, texc_pkg::ST_OK, e_key[f], e_handle[f],
                        e_hints[f], 1'b1);
            end
         end
         default: begin
            while (held > 0) drop_entry(oldest);
            push_rsp(texc_pkg::KIND_FINAL, texc_pkg::ST_OK, '0, '0, '0, 1'b1);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      cache_rsp_type got, exp_r;
      if (reset) begin
         budget     <= texc_pkg::MAX_BYTES_RST;
         held_bytes = '0;
         held       = 0;
         oldest     = 0;
         newest     = 0;
         for (int i = 0; i < SLOTS; i++) e_valid[i] = 1'b0;
         expected_rsps.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         // results first: the request seen in this cycle cannot answer yet
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_kind, rsp_status, rsp_key_out, rsp_handle_out, rsp_hints_out,
                    rsp_total_bytes, rsp_entry_count, rsp_last};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (got !== exp_r) begin
                  $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            predict_request(req_action, req_key, req_entry_handle, req_entry_hints,
                            req_pixel_kind, req_tex_width, req_tex_height);
         if (csr_wr_en) budget <= csr_wr_data;
         pending_count <= expected_rsps.size();
      end
   end

endmodule

### bench/tb_size_bounded_fifo_texture_cache_unit.sv
`timescale 1ns / 1ps

module tb_size_bounded_fifo_texture_cache_unit;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = texc_pkg::ACT_GET;
   logic [31:0] req_key = '0;
   logic [31:0] req_entry_handle = '0;
   logic [15:0] req_entry_hints = '0;
   logic [2:0]  req_pixel_kind = texc_pkg::PK_LUM8;
   logic [14:0] req_tex_width = '0;
   logic [14:0] req_tex_height = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_key_out, rsp_handle_out;
   logic [15:0] rsp_hints_out;
   logic [35:0] rsp_total_bytes;
   logic [5:0]  rsp_entry_count;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [35:0] csr_wr_data = '0;
   int          fail_count, pending_count;
   int          quiet_cycles = 0;
   int          stall_left = 0;

   localparam int QUIET_LIMIT = 20000;

   always #5 clock = ~clock;

   size_bounded_fifo_texture_cache_unit dut (.*);

   texc_checker chk (.*);

   // Keys drawn from a small pool so puts hit existing entries and gets/removes mostly find
   logic [31:0] key_pool [8];

   // Result side stalls: open stretches, mostly short stalls, a few long ones
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else if (r < 55) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall  <= 1'b1;
         stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_size_bounded_fifo_texture_cache_unit: FAIL");
         $finish;
      end
   end

   // valid stays high into the next transaction when there is no gap
   task automatic send_request(logic [1:0] act, logic [31:0] k, logic [31:0] hd,
                               logic [15:0] hn, logic [2:0] pk,
                               logic [14:0] w, logic [14:0] h);
      int gap;
      // random idle before the transaction: mostly short, a few long
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_key          <= k;
      req_entry_handle <= hd;
      req_entry_hints  <= hn;
      req_pixel_kind   <= pk;
      req_tex_width    <= w;
      req_tex_height   <= h;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic set_budget(logic [35:0] v);
      // drain, then let the sequencer settle before touching the register
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_request();
      logic [1:0]  act;
      logic [2:0]  pk;
      logic [14:0] w, h;
      int          r;
      r = $urandom_range(0, 99);
      act = (r < 50) ? texc_pkg::ACT_PUT : (r < 75) ? texc_pkg::ACT_GET :
            (r < 96) ? texc_pkg::ACT_REMOVE : texc_pkg::ACT_CLEAR;
      pk  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      // sizes mostly small; occasionally anything the field holds
      if ($urandom_range(0, 19) == 0) begin
         w = 15'($urandom);
         h = 15'($urandom);
      end else begin
         w = 15'($urandom_range(0, 64));
         h = 15'($urandom_range(0, 64));
      end
      send_request(act, ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, 7)],
                   $urandom, 16'($urandom), pk, w, h);
   endtask

   initial begin
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every action, invalid formats, misses, extremes
      send_request(texc_pkg::ACT_GET, 32'h0, '0, '0, texc_pkg::PK_LUM8, '0, '0);
      send_request(texc_pkg::ACT_REMOVE, 32'hFFFF_FFFF, '0, '0, texc_pkg::PK_LUM8, '0, '0);
      send_request(texc_pkg::ACT_PUT, 32'h0, 32'h0, 16'h0, texc_pkg::PK_LUM8, 15'd0, 15'd0);
      send_request(texc_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                   texc_pkg::PK_RGBA8, 15'h7FFF, 15'h7FFF);
      send_request(texc_pkg::ACT_PUT, 32'h1, 32'h11, 16'h1, 3'd6, 15'd4, 15'd4);
      send_request(texc_pkg::ACT_PUT, 32'h2, 32'h22, 16'h2, 3'd7, 15'd4, 15'd4);
      send_request(texc_pkg::ACT_PUT, 32'h3, 32'h33, 16'h3, texc_pkg::PK_LUMALPHA8,
                   15'd8, 15'd8);
      send_request(texc_pkg::ACT_PUT, 32'h4, 32'h44, 16'h4, texc_pkg::PK_RGB8,
                   15'd16384, 15'd16384);
      send_request(texc_pkg::ACT_PUT, 32'h5, 32'h55, 16'h5, texc_pkg::PK_RGBA5551,
                   15'd3, 15'd5);
      send_request(texc_pkg::ACT_PUT, 32'h5, 32'h56, 16'h6, texc_pkg::PK_RGB565,
                   15'd7, 15'd9);
      send_request(texc_pkg::ACT_GET, 32'h5, '0, '0, texc_pkg::PK_LUM8, '0, '0);
      send_request(texc_pkg::ACT_REMOVE, 32'h5, '0, '0, texc_pkg::PK_LUM8, '0, '0);
      // fill past capacity so the full-table eviction fires
      for (int i = 0; i < 34; i++)
         send_request(texc_pkg::ACT_PUT, 32'h100 + i, $urandom, 16'($urandom),
                      texc_pkg::PK_LUM8, 15'd1, 15'd1);
      send_request(texc_pkg::ACT_CLEAR, '0, '0, '0, texc_pkg::PK_LUM8, '0, '0);

      // budget settings: zero, tiny, all ones, back to reset value
      set_budget(36'd0);
      for (int i = 0; i < 60; i++) random_request();
      set_budget(36'd5000);
      for (int i = 0; i < 80; i++) random_request();
      set_budget(36'hF_FFFF_FFFF);
      send_request(texc_pkg::ACT_PUT, 32'h7, '0, '0, texc_pkg::PK_RGBA8, 15'h7FFF, 15'h7FFF);
      send_request(texc_pkg::ACT_PUT, 32'h8, '0, '0, texc_pkg::PK_RGBA8, 15'h7FFF, 15'h7FFF);
      for (int i = 0; i < 60; i++) random_request();
      set_budget(texc_pkg::MAX_BYTES_RST);
      for (int i = 0; i < 50; i++) random_request();

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("tb_size_bounded_fifo_texture_cache_unit: PASS");
      else
         $display("tb_size_bounded_fifo_texture_cache_unit: FAIL");
      $finish;
   end

endmodule
